// ===== sv/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and codes for the periodic trigger table: request codes,
// status codes, slot flag bits, the slot entry layout and the sequencer states.
// ----------------------------------------------------------------------------
package ptt_pkg;

    localparam int VALUE_W   = 32;
    localparam int SLOT_W    = 4;
    localparam int FLAGS_W   = 8;
    localparam int REQ_W     = 4;
    localparam int STATUS_W  = 2;
    localparam int MAX_RES   = 16;
    localparam int FIRE_CNT_W = 5;

    // Flag bit positions
    localparam int FLAG_ACTIVE = 0;
    localparam int FLAG_GLOBAL = 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK        = 4'd0,
        REQ_INSERT      = 4'd1,
        REQ_REMOVE      = 4'd2,
        REQ_SET_PERIOD  = 4'd3,
        REQ_SET_COUNT   = 4'd4,
        REQ_SET_FLAGS   = 4'd5,
        REQ_GET_FLAGS   = 4'd6,
        REQ_READ_TICKS  = 4'd7,
        REQ_WRITE_TICKS = 4'd8
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_ARG = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    // One slot as stored in the table memory
    typedef struct packed {
        logic [VALUE_W-1:0] period;
        logic [VALUE_W-1:0] count;
        logic [FLAGS_W-1:0] flags;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_INS_END,
        S_MOD,
        S_FLUSH,
        S_RESP
    } state_t;

endpackage

// ===== sv/ptt_if.sv =====
// ----------------------------------------------------------------------------
// ptt_if
// Valid/ready channels of the periodic trigger table: the request channel
// and the result channel.
// ----------------------------------------------------------------------------
interface ptt_req_if
    import ptt_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
    logic [FLAGS_W-1:0] flag_bits;

    modport source (output valid, req_type, slot, value, flag_bits, input ready);
    modport sink   (input valid, req_type, slot, value, flag_bits, output ready);
endinterface

interface ptt_res_if
    import ptt_pkg::*;
    ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                fired;
    logic [SLOT_W-1:0]   slot_index;
    logic [VALUE_W-1:0]  read_value;
    logic                last;

    modport source (output valid, status, fired, slot_index, read_value, last,
                    input ready);
    modport sink   (input valid, status, fired, slot_index, read_value, last,
                    output ready);
endinterface

// ===== sv/ptt_ram.sv =====
// ----------------------------------------------------------------------------
// ptt_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/periodic_trigger_table.sv =====
// ----------------------------------------------------------------------------
// periodic_trigger_table
// Table of periodic triggers stepped by a global tick. Slot state lives in one
// synchronous RAM; a sequencer reads, updates and writes back slot entries.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------
//  req     | in  | req_type, slot, value, flag_bits
//  rsp     | out | status, fired, slot_index, read_value, last
//
//  A tick reads slot 0 in the accept cycle, then evaluates one slot per cycle
//  while rsp does not stall, then flushes the held firing if any slot fired.
//  An insert walks the slots to reuse an inactive one or else appends at the end,
//  and responds without a RAM access on a zero period; other slot requests read,
//  modify and respond, or just respond on a bad slot; tick reads and writes respond directly. Reset clears the
//  global count, slots_used and the sequencer; no RAM clear. A stall on rsp holds
//  the walk at the slot that cannot report and keeps req.ready low.
// ----------------------------------------------------------------------------
module periodic_trigger_table
    import ptt_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    ptt_req_if.sink  req,
    ptt_res_if.source rsp
);

    localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;

    // Control state
    state_t                state_reg, state_next;
    logic [VALUE_W-1:0]    ticks_reg, ticks_next;
    logic [CW-1:0]         used_reg, used_next;
    logic [FIRE_CNT_W-1:0] n_reg, n_next;
    logic                  out_valid_reg, out_valid_next;

    // Request and walk payload
    req_type_t             op_reg, op_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [VALUE_W-1:0]    value_reg, value_next;
    logic [FLAGS_W-1:0]    flags_reg, flags_next;
    logic [CW-1:0]         i_reg, i_next;
    logic [SLOT_W-1:0]     pend_reg, pend_next;
    status_t               res_st_reg, res_st_next;
    logic [SLOT_W-1:0]     res_idx_reg, res_idx_next;
    logic [VALUE_W-1:0]    res_rv_reg, res_rv_next;

    // Output register
    logic [STATUS_W-1:0]   o_status_reg;
    logic                  o_fired_reg;
    logic [SLOT_W-1:0]     o_idx_reg;
    logic [VALUE_W-1:0]    o_rv_reg;
    logic                  o_last_reg;

    // Push into the output register
    logic                  push;
    logic [STATUS_W-1:0]   push_status;
    logic                  push_fired;
    logic [SLOT_W-1:0]     push_idx;
    logic [VALUE_W-1:0]    push_rv;
    logic                  push_last;

    // RAM ports
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    entry_t                ram_wdata, rd_entry;
    logic [ENTRY_W-1:0]    ram_rdata;

    // Walk helpers
    logic                  out_free;
    logic [CW-1:0]         i_inc;
    logic                  last_slot;
    logic                  slot_ok;
    logic                  e_active, e_global;
    logic [VALUE_W-1:0]    cnt_inc;
    logic                  fire, report, walk_stall;

    ptt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry  = entry_t'(ram_rdata);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign i_inc     = i_reg + 1'b1;
    assign last_slot = (i_inc == used_reg);
    assign slot_ok   = CMPW'(req.slot) < CMPW'(used_reg);

    // Evaluate the slot under the walk
    assign e_active  = rd_entry.flags[FLAG_ACTIVE];
    assign e_global  = rd_entry.flags[FLAG_GLOBAL];
    assign cnt_inc   = rd_entry.count + 1'b1;
    always_comb
    begin
        if (e_global)
        begin
            fire = e_active && (ticks_reg >= rd_entry.period);
        end
        else
        begin
            fire = e_active && (cnt_inc >= rd_entry.period);
        end
    end
    assign report     = fire && (n_reg < FIRE_CNT_W'(MAX_RES));
    assign walk_stall = report && (n_reg != '0) && !out_free;

    assign req.ready  = (state_reg == S_IDLE);

    // Sequencer: next state, RAM access and result pushes
    always_comb
    begin
        state_next   = state_reg;
        ticks_next   = ticks_reg;
        used_next    = used_reg;
        n_next       = n_reg;
        op_next      = op_reg;
        slot_next    = slot_reg;
        value_next   = value_reg;
        flags_next   = flags_reg;
        i_next       = i_reg;
        pend_next    = pend_reg;
        res_st_next  = res_st_reg;
        res_idx_next = res_idx_reg;
        res_rv_next  = res_rv_reg;
        ram_we       = 1'b0;
        ram_waddr    = i_reg[AW-1:0];
        ram_wdata    = rd_entry;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        push         = 1'b0;
        push_status  = ST_OK;
        push_fired   = 1'b0;
        push_idx     = '0;
        push_rv      = '0;
        push_last    = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = req_type_t'(req.req_type);
                    slot_next    = req.slot;
                    value_next   = req.value;
                    flags_next   = req.flag_bits;
                    i_next       = '0;
                    n_next       = '0;
                    res_st_next  = ST_OK;
                    res_idx_next = '0;
                    res_rv_next  = '0;
                    state_next   = S_RESP;
                    case (req_type_t'(req.req_type))
                        REQ_TICK:
                        begin
                            ticks_next = ticks_reg + 1'b1;
                            if (used_reg != '0)
                            begin
                                ram_re     = 1'b1;
                                state_next = S_WALK;
                            end
                            else
                            begin
                                state_next = S_IDLE;
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (req.value == '0)
                            begin
                                res_st_next = ST_BAD_ARG;
                            end
                            else if (used_reg == '0)
                            begin
                                state_next = S_INS_END;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                state_next = S_WALK;
                            end
                        end
                        REQ_REMOVE, REQ_SET_COUNT, REQ_SET_FLAGS, REQ_GET_FLAGS:
                        begin
                            if (!slot_ok)
                            begin
                                res_st_next = ST_BAD_ARG;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(req.slot);
                                state_next = S_MOD;
                            end
                        end
                        REQ_SET_PERIOD:
                        begin
                            if (!slot_ok || req.value == '0)
                            begin
                                res_st_next = ST_BAD_ARG;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(req.slot);
                                state_next = S_MOD;
                            end
                        end
                        REQ_READ_TICKS:
                        begin
                            res_rv_next = ticks_reg;
                        end
                        REQ_WRITE_TICKS:
                        begin
                            ticks_next = req.value;
                        end
                        default:
                        begin
                            res_st_next = ST_OK;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                if (op_reg == REQ_TICK)
                begin
                    if (!walk_stall)
                    begin
                        // Write back the local count
                        if (e_active && !e_global)
                        begin
                            ram_we          = 1'b1;
                            ram_wdata.count = fire ? '0 : cnt_inc;
                        end
                        // Report the held firing, hold the new one
                        if (report)
                        begin
                            if (n_reg != '0)
                            begin
                                push       = 1'b1;
                                push_fired = 1'b1;
                                push_idx   = pend_reg;
                                push_last  = 1'b0;
                            end
                            pend_next = SLOT_W'(i_reg);
                            n_next    = n_reg + 1'b1;
                        end
                        if (last_slot)
                        begin
                            state_next = (n_next != '0) ? S_FLUSH : S_IDLE;
                        end
                        else
                        begin
                            i_next    = i_inc;
                            ram_re    = 1'b1;
                            ram_raddr = i_inc[AW-1:0];
                        end
                    end
                end
                else
                begin
                    // Insert: search for the first inactive slot
                    if (!e_active)
                    begin
                        ram_we           = 1'b1;
                        ram_wdata.period = value_reg;
                        ram_wdata.count  = '0;
                        ram_wdata.flags  = flags_reg | FLAGS_W'(1 << FLAG_ACTIVE);
                        res_idx_next     = SLOT_W'(i_reg);
                        state_next       = S_RESP;
                    end
                    else if (last_slot)
                    begin
                        state_next = S_INS_END;
                    end
                    else
                    begin
                        i_next    = i_inc;
                        ram_re    = 1'b1;
                        ram_raddr = i_inc[AW-1:0];
                    end
                end
            end

            S_INS_END:
            begin
                // Append a new slot unless the table is full
                if (used_reg < CW'(SLOTS))
                begin
                    ram_we           = 1'b1;
                    ram_waddr        = used_reg[AW-1:0];
                    ram_wdata.period = value_reg;
                    ram_wdata.count  = '0;
                    ram_wdata.flags  = flags_reg | FLAGS_W'(1 << FLAG_ACTIVE);
                    res_idx_next     = SLOT_W'(used_reg);
                    used_next        = used_reg + 1'b1;
                end
                else
                begin
                    res_st_next = ST_FULL;
                end
                state_next = S_RESP;
            end

            S_MOD:
            begin
                ram_waddr  = AW'(slot_reg);
                state_next = S_RESP;
                case (op_reg)
                    REQ_REMOVE:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = '0;
                    end
                    REQ_SET_PERIOD:
                    begin
                        ram_we           = 1'b1;
                        ram_wdata.period = value_reg;
                    end
                    REQ_SET_COUNT:
                    begin
                        ram_we          = 1'b1;
                        ram_wdata.count = value_reg;
                    end
                    REQ_SET_FLAGS:
                    begin
                        ram_we          = 1'b1;
                        ram_wdata.flags = flags_reg;
                    end
                    REQ_GET_FLAGS:
                    begin
                        res_rv_next = VALUE_W'(rd_entry.flags);
                    end
                    default:
                    begin
                        ram_we = 1'b0;
                    end
                endcase
            end

            S_FLUSH:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    push_fired = 1'b1;
                    push_idx   = pend_reg;
                    state_next = S_IDLE;
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    push        = 1'b1;
                    push_status = res_st_reg;
                    push_idx    = res_idx_reg;
                    push_rv     = res_rv_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold a beat until the sink takes it
    always_comb
    begin
        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !rsp.ready;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ticks_reg     <= '0;
            used_reg      <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ticks_reg     <= ticks_next;
            used_reg      <= used_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        slot_reg    <= slot_next;
        value_reg   <= value_next;
        flags_reg   <= flags_next;
        i_reg       <= i_next;
        pend_reg    <= pend_next;
        res_st_reg  <= res_st_next;
        res_idx_reg <= res_idx_next;
        res_rv_reg  <= res_rv_next;
        if (push)
        begin
            o_status_reg <= push_status;
            o_fired_reg  <= push_fired;
            o_idx_reg    <= push_idx;
            o_rv_reg     <= push_rv;
            o_last_reg   <= push_last;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = o_status_reg;
    assign rsp.fired      = o_fired_reg;
    assign rsp.slot_index = o_idx_reg;
    assign rsp.read_value = o_rv_reg;
    assign rsp.last       = o_last_reg;

endmodule

// ===== tb/periodic_trigger_table_tb.sv =====
// ----------------------------------------------------------------------------
// periodic_trigger_table_tb
// Self-checking bench for the periodic trigger table. A short table of
// directed requests runs first, then about 480 random requests grouped in
// bursts. Bursts are mixed traffic, insert storms that fill the table, tick
// runs and noise. A cycle-free predictor mirrors the slot table and builds the
// expected result beats. Every result beat is compared in order. Both channel
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module periodic_trigger_table_tb;
    import ptt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 16;
    localparam int RANDOM_ITEMS = 480;
    localparam int REPORT_LIMIT = 10;

    // Request codes the block does not define
    localparam logic [REQ_W-1:0] REQ_RESERVED_FIRST = 4'd9;
    localparam logic [REQ_W-1:0] REQ_RESERVED_LAST  = 4'd15;

    typedef enum int {
        MIX_NORMAL,
        MIX_FILL,
        MIX_TICKS,
        MIX_NOISE
    } burst_t;

    typedef struct packed {
        status_t             status;
        logic                fired;
        logic [SLOT_W-1:0]   slot_index;
        logic [VALUE_W-1:0]  read_value;
        logic                last;
    } result_t;

    typedef struct {
        logic [REQ_W-1:0]   kind;
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
        logic [FLAGS_W-1:0] flags;
        bit                 fixed;
        result_t            fixed_res;
    } stim_t;

    logic clk = 1'b0;
    logic rst_n;

    ptt_req_if req_ch ();
    ptt_res_if res_ch ();

    periodic_trigger_table #(
        .SLOTS (SLOTS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (res_ch)
    );

    always #5ns clk = ~clk;

    // Mirror of the slot table
    logic [VALUE_W-1:0] tick_total;
    int                 slots_in_use;
    logic [VALUE_W-1:0] trig_period [SLOTS];
    logic [VALUE_W-1:0] trig_count  [SLOTS];
    logic [FLAGS_W-1:0] trig_flags  [SLOTS];

    result_t step_results [$];
    result_t pending      [$];
    int      mismatches = 0;
    bit      calm = 1'b0;

    function automatic result_t make_result(status_t st, logic fired, int idx,
                                            logic [VALUE_W-1:0] rv, logic last);
        result_t r;
        r.status     = st;
        r.fired      = fired;
        r.slot_index = SLOT_W'(idx);
        r.read_value = rv;
        r.last       = last;
        return r;
    endfunction

    // Update the mirror for one accepted request and list its result beats
    function automatic void model_request(stim_t s);
        int  n;
        int  idx;
        bit  fire;
        bit  in_range;
        step_results.delete();
        in_range = (int'(s.slot) < slots_in_use);
        case (s.kind)
            REQ_TICK: begin
                n = 0;
                tick_total = tick_total + 1'b1;
                for (int i = 0; i < slots_in_use; i++) begin
                    if (!trig_flags[i][FLAG_ACTIVE])
                        continue;
                    fire = 1'b0;
                    if (trig_flags[i][FLAG_GLOBAL]) begin
                        fire = (tick_total >= trig_period[i]);
                    end
                    else begin
                        trig_count[i] = trig_count[i] + 1'b1;
                        if (trig_count[i] >= trig_period[i]) begin
                            trig_count[i] = '0;
                            fire = 1'b1;
                        end
                    end
                    if (fire && n < MAX_RES) begin
                        step_results.push_back(make_result(ST_OK, 1'b1, i, '0, 1'b0));
                        n++;
                    end
                end
                if (n > 0)
                    step_results[n-1].last = 1'b1;
            end
            REQ_INSERT: begin
                if (s.value == '0) begin
                    step_results.push_back(make_result(ST_BAD_ARG, 1'b0, 0, '0, 1'b1));
                end
                else begin
                    idx = slots_in_use;
                    for (int i = 0; i < slots_in_use; i++) begin
                        if (!trig_flags[i][FLAG_ACTIVE]) begin
                            idx = i;
                            break;
                        end
                    end
                    if (idx == slots_in_use && slots_in_use >= SLOTS) begin
                        step_results.push_back(make_result(ST_FULL, 1'b0, 0, '0, 1'b1));
                    end
                    else begin
                        if (idx == slots_in_use)
                            slots_in_use++;
                        trig_period[idx] = s.value;
                        trig_count[idx]  = '0;
                        trig_flags[idx]  = s.flags | FLAGS_W'(1 << FLAG_ACTIVE);
                        step_results.push_back(make_result(ST_OK, 1'b0, idx, '0, 1'b1));
                    end
                end
            end
            REQ_REMOVE, REQ_SET_COUNT, REQ_SET_FLAGS, REQ_GET_FLAGS: begin
                if (!in_range) begin
                    step_results.push_back(make_result(ST_BAD_ARG, 1'b0, 0, '0, 1'b1));
                end
                else if (s.kind == REQ_GET_FLAGS) begin
                    step_results.push_back(make_result(ST_OK, 1'b0, 0,
                        VALUE_W'(trig_flags[s.slot]), 1'b1));
                end
                else begin
                    if (s.kind == REQ_REMOVE) begin
                        trig_period[s.slot] = '0;
                        trig_count[s.slot]  = '0;
                        trig_flags[s.slot]  = '0;
                    end
                    else if (s.kind == REQ_SET_COUNT) begin
                        trig_count[s.slot] = s.value;
                    end
                    else begin
                        trig_flags[s.slot] = s.flags;
                    end
                    step_results.push_back(make_result(ST_OK, 1'b0, 0, '0, 1'b1));
                end
            end
            REQ_SET_PERIOD: begin
                if (!in_range || s.value == '0) begin
                    step_results.push_back(make_result(ST_BAD_ARG, 1'b0, 0, '0, 1'b1));
                end
                else begin
                    trig_period[s.slot] = s.value;
                    step_results.push_back(make_result(ST_OK, 1'b0, 0, '0, 1'b1));
                end
            end
            REQ_READ_TICKS: begin
                step_results.push_back(make_result(ST_OK, 1'b0, 0, tick_total, 1'b1));
            end
            REQ_WRITE_TICKS: begin
                tick_total = s.value;
                step_results.push_back(make_result(ST_OK, 1'b0, 0, '0, 1'b1));
            end
            default: begin
                step_results.push_back(make_result(ST_OK, 1'b0, 0, '0, 1'b1));
            end
        endcase
    endfunction

    function automatic stim_t row(logic [REQ_W-1:0] kind, logic [SLOT_W-1:0] slot,
                                  logic [VALUE_W-1:0] value, logic [FLAGS_W-1:0] flags,
                                  bit fixed, status_t st, int idx,
                                  logic [VALUE_W-1:0] rv);
        stim_t s;
        s.kind      = kind;
        s.slot      = slot;
        s.value     = value;
        s.flags     = flags;
        s.fixed     = fixed;
        s.fixed_res = make_result(st, 1'b0, idx, rv, 1'b1);
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_period(bit allow_zero);
        int r;
        r = $urandom_range(0, 99);
        if (allow_zero && r < 10)
            return '0;
        if (r < 65)
            return VALUE_W'($urandom_range(1, 6));
        if (r < 85)
            return VALUE_W'($urandom_range(7, 40));
        return $urandom | 32'd1;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return VALUE_W'($urandom_range(0, 8));
        if (r < 75)
            return $urandom;
        return 32'hFFFF_FFFF - VALUE_W'($urandom_range(0, 3));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_ticks();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return VALUE_W'($urandom_range(0, 20));
        if (r < 70)
            return $urandom;
        return 32'hFFFF_FFF0 + VALUE_W'($urandom_range(0, 15));
    endfunction

    // Mostly a slot in use, sometimes any index
    function automatic logic [SLOT_W-1:0] pick_slot();
        if (slots_in_use > 0 && $urandom_range(0, 9) < 8)
            return SLOT_W'($urandom_range(0, slots_in_use - 1));
        return SLOT_W'($urandom_range(0, 15));
    endfunction

    function automatic stim_t random_request(burst_t mix);
        stim_t s;
        int    r;
        s.kind      = REQ_TICK;
        s.slot      = SLOT_W'($urandom_range(0, 15));
        s.value     = $urandom;
        s.flags     = FLAGS_W'($urandom_range(0, 255));
        s.fixed     = 1'b0;
        s.fixed_res = '0;
        case (mix)
            MIX_FILL: begin
                s.kind  = REQ_INSERT;
                s.value = pick_period(1'b0);
            end
            MIX_TICKS: begin
                s.kind = REQ_TICK;
            end
            MIX_NOISE: begin
                s.kind = REQ_W'($urandom_range(0, 15));
            end
            default: begin
                r = $urandom_range(0, 99);
                if (r < 34) begin
                    s.kind = REQ_TICK;
                end
                else if (r < 52) begin
                    s.kind  = REQ_INSERT;
                    s.value = pick_period(1'b1);
                end
                else if (r < 60) begin
                    s.kind = REQ_REMOVE;
                    s.slot = pick_slot();
                end
                else if (r < 67) begin
                    s.kind  = REQ_SET_PERIOD;
                    s.slot  = pick_slot();
                    s.value = pick_period(1'b1);
                end
                else if (r < 74) begin
                    s.kind  = REQ_SET_COUNT;
                    s.slot  = pick_slot();
                    s.value = pick_count();
                end
                else if (r < 81) begin
                    s.kind = REQ_SET_FLAGS;
                    s.slot = pick_slot();
                    if ($urandom_range(0, 9) < 7)
                        s.flags[FLAG_ACTIVE] = 1'b1;
                end
                else if (r < 87) begin
                    s.kind = REQ_GET_FLAGS;
                    s.slot = pick_slot();
                end
                else if (r < 91) begin
                    s.kind = REQ_READ_TICKS;
                end
                else if (r < 95) begin
                    s.kind  = REQ_WRITE_TICKS;
                    s.value = pick_ticks();
                end
                else begin
                    s.kind = REQ_W'($urandom_range(REQ_RESERVED_FIRST, REQ_RESERVED_LAST));
                end
            end
        endcase
        return s;
    endfunction

    // Drive one request beat and queue what it should produce
    task automatic send_request(stim_t s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= s.kind;
        req_ch.slot      <= s.slot;
        req_ch.value     <= s.value;
        req_ch.flag_bits <= s.flags;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        model_request(s);
        if (s.fixed)
            pending.push_back(s.fixed_res);
        else
            foreach (step_results[k])
                pending.push_back(step_results[k]);
        @(negedge clk);
    endtask

    // Hold the request side until every queued result has come back
    task automatic wait_drained(int hold);
        req_ch.valid <= 1'b0;
        while (pending.size() != 0)
            @(negedge clk);
        repeat (hold) @(negedge clk);
    endtask

    // Result side: random stalls, short mostly, long now and then
    initial begin
        int stall_left;
        int r;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (calm) begin
                res_ch.ready <= 1'b1;
            end
            else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    res_ch.ready <= 1'b1;
                end
                else if (r < 96) begin
                    res_ch.ready <= 1'b0;
                    stall_left = $urandom_range(0, 2);
                end
                else begin
                    res_ch.ready <= 1'b0;
                    stall_left = $urandom_range(8, 23);
                end
            end
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk) begin
        result_t got;
        result_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            got.status     = status_t'(res_ch.status);
            got.fired      = res_ch.fired;
            got.slot_index = res_ch.slot_index;
            got.read_value = res_ch.read_value;
            got.last       = res_ch.last;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result beat: st=%0d fired=%0d slot=%0d value=%h last=%0d",
                             got.status, got.fired, got.slot_index, got.read_value, got.last);
            end
            else begin
                want = pending.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result mismatch: expected st=%0d fired=%0d slot=%0d value=%h last=%0d, got st=%0d fired=%0d slot=%0d value=%h last=%0d",
                                 want.status, want.fired, want.slot_index, want.read_value,
                                 want.last, got.status, got.fired, got.slot_index,
                                 got.read_value, got.last);
                end
            end
        end
    end

    // Stop a hung run
    initial begin
        #10ms;
        $display("periodic_trigger_table verification failed");
        $finish;
    end

    initial begin
        stim_t  directed [$];
        stim_t  s;
        burst_t mix;
        int     len;
        int     sent;
        int     r;
        bit     paused;

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = '0;
        req_ch.slot      = '0;
        req_ch.value     = '0;
        req_ch.flag_bits = '0;
        tick_total       = '0;
        slots_in_use     = 0;
        foreach (trig_period[i]) begin
            trig_period[i] = '0;
            trig_count[i]  = '0;
            trig_flags[i]  = '0;
        end

        // Directed requests: fixed answers where obvious, predictor elsewhere
        directed.push_back(row(REQ_READ_TICKS,  0, 0, 0, 1, ST_OK, 0, 0));
        directed.push_back(row(REQ_GET_FLAGS,   0, 0, 0, 1, ST_BAD_ARG, 0, 0));
        directed.push_back(row(REQ_INSERT,      0, 0, 0, 1, ST_BAD_ARG, 0, 0));
        directed.push_back(row(REQ_TICK,        0, 0, 0, 0, ST_OK, 0, 0));
        directed.push_back(row(REQ_INSERT,      0, 1, 8'h00, 1, ST_OK, 0, 0));
        directed.push_back(row(REQ_INSERT,      0, 3, 8'hFE, 1, ST_OK, 1, 0));
        directed.push_back(row(REQ_GET_FLAGS,   1, 0, 0, 1, ST_OK, 0, 32'h0000_00FF));
        directed.push_back(row(REQ_TICK,        0, 0, 0, 0, ST_OK, 0, 0));
        directed.push_back(row(REQ_TICK,        0, 0, 0, 0, ST_OK, 0, 0));
        directed.push_back(row(REQ_SET_PERIOD,  0, 0, 0, 1, ST_BAD_ARG, 0, 0));
        directed.push_back(row(REQ_SET_PERIOD,  0, 32'hFFFF_FFFF, 0, 1, ST_OK, 0, 0));
        directed.push_back(row(REQ_SET_COUNT,   0, 32'hFFFF_FFFE, 0, 1, ST_OK, 0, 0));
        directed.push_back(row(REQ_TICK,        0, 0, 0, 0, ST_OK, 0, 0));
        directed.push_back(row(REQ_SET_FLAGS,  15, 0, 8'hFF, 1, ST_BAD_ARG, 0, 0));
        directed.push_back(row(REQ_SET_FLAGS,   0, 0, 8'h00, 1, ST_OK, 0, 0));
        directed.push_back(row(REQ_INSERT,      0, 5, 8'h80, 1, ST_OK, 0, 0));
        directed.push_back(row(REQ_REMOVE,      1, 0, 0, 1, ST_OK, 0, 0));
        // active again with period zero: fires on every tick
        directed.push_back(row(REQ_SET_FLAGS,   1, 0, 8'h01, 1, ST_OK, 0, 0));
        directed.push_back(row(REQ_WRITE_TICKS, 0, 32'hFFFF_FFFF, 0, 1, ST_OK, 0, 0));
        directed.push_back(row(REQ_TICK,        0, 0, 0, 0, ST_OK, 0, 0));
        directed.push_back(row(REQ_READ_TICKS,  0, 0, 0, 1, ST_OK, 0, 0));
        directed.push_back(row(REQ_RESERVED_FIRST, 0, 0, 0, 1, ST_OK, 0, 0));
        directed.push_back(row(REQ_RESERVED_LAST, 15, 32'hFFFF_FFFF, 8'hFF, 1, ST_OK, 0, 0));
        directed.push_back(row(REQ_REMOVE,     14, 0, 0, 1, ST_BAD_ARG, 0, 0));
        directed.push_back(row(REQ_GET_FLAGS,   0, 0, 0, 1, ST_OK, 0, 32'h0000_0081));

        // Hold reset, then release between edges
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[k])
            send_request(directed[k]);

        // Random bursts
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                mix = MIX_NORMAL;
                len = $urandom_range(12, 24);
            end
            else if (r < 72) begin
                mix = MIX_FILL;
                len = 18;
            end
            else if (r < 90) begin
                mix = MIX_TICKS;
                len = $urandom_range(6, 14);
            end
            else begin
                mix = MIX_NOISE;
                len = $urandom_range(4, 8);
            end
            calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < len; k++) begin
                s = random_request(mix);
                send_request(s);
                sent++;
            end
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                paused = 1'b1;
                wait_drained(24);
            end
        end

        // Drain and let any walk in progress finish
        wait_drained(64);
        if (mismatches == 0 && pending.size() == 0)
            $display("periodic_trigger_table verification clean");
        else
            $display("periodic_trigger_table verification failed");
        $finish;
    end

endmodule
